### design/slm_pkg.sv
`default_nettype none
package slm_pkg;

	localparam int unsigned LEVEL_W = 10;
	localparam int unsigned LED_N   = 8;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned LIM_W   = 15;
	localparam int unsigned CFG_W   = 8;

	localparam logic [LIM_W-1:0] HOLD_UNIT = 15'd100;
	localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// ascending thresholds, LED i lights when level exceeds entry i
	localparam logic [LEVEL_W-1:0] LADDER [LED_N] = '{
		10'd130, 10'd220, 10'd330, 10'd440, 10'd520, 10'd570, 10'd680, 10'd870
	};

	typedef enum logic [1:0] {
		MODE_ALL_ON  = 2'd0,
		MODE_BAR     = 2'd1,
		MODE_ALL_OFF = 2'd2,
		MODE_DOT     = 2'd3
	} mode_t;

	typedef enum logic {
		REG_PEAK_MODE     = 1'b0,
		REG_HOLD_HUNDREDS = 1'b1
	} reg_idx_t;

	// hit low means the level sits at or below the lowest threshold
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} level_idx_t;

	typedef struct packed {
		logic             update;
		logic             clear;
		logic             dot;
		logic [LIM_W-1:0] limit;
	} chan_ctrl_t;

endpackage
`default_nettype wire

### design/slm_ladder.sv
`default_nettype none
module slm_ladder
	import slm_pkg::*;
(
	input  wire logic [LEVEL_W-1:0] level,
	output level_idx_t              index
);

	always_comb begin
		index.hit = 1'b0;
		index.idx = '0;
		for (int i = 0; i < LED_N; i++) begin
			if (level > LADDER[i]) begin
				index.hit = 1'b1;
				index.idx = IDX_W'(i);
			end
		end
	end

endmodule
`default_nettype wire

### design/slm_chan.sv
`default_nettype none
module slm_chan
	import slm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire chan_ctrl_t   ctrl,
	input  wire level_idx_t   index,
	output logic [LED_N-1:0]  pattern_next
);

	logic [IDX_W-1:0] peak_q;
	logic [CNT_W-1:0] count_q;
	logic [LED_N-1:0] pattern_q;

	logic             rise;
	logic             decay;
	logic [CNT_W-1:0] count_inc;
	logic [IDX_W-1:0] peak_next;
	logic [CNT_W-1:0] count_next;
	logic [IDX_W-1:0] peak_dn;

	assign rise      = index.hit && (index.idx >= peak_q);
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + CNT_W'(1);
	assign decay     = !rise && (count_inc >= CNT_W'(ctrl.limit));
	assign peak_dn   = (peak_q != '0) ? peak_q - IDX_W'(1) : '0;

	always_comb begin
		pattern_next = pattern_q;
		peak_next    = peak_q;
		count_next   = count_inc;
		if (rise) begin
			peak_next  = index.idx;
			count_next = '0;
			if (ctrl.dot) begin
				pattern_next = LED_N'(1) << index.idx;
			end else begin
				// fill from the old peak up to the new index
				for (int i = 0; i < LED_N; i++) begin
					if (IDX_W'(i) >= peak_q && IDX_W'(i) <= index.idx)
						pattern_next[i] = 1'b1;
				end
			end
		end else if (decay) begin
			peak_next  = peak_dn;
			count_next = '0;
			if (ctrl.dot) begin
				pattern_next = (peak_q != '0) ? LED_N'(1) << peak_dn : '0;
			end else begin
				pattern_next[peak_q] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q    <= '0;
			count_q   <= '0;
			pattern_q <= '0;
		end else if (ctrl.clear) begin
			// mode change drops the peak display, counter kept
			peak_q    <= '0;
			pattern_q <= '0;
		end else if (ctrl.update) begin
			peak_q    <= peak_next;
			count_q   <= count_next;
			pattern_q <= pattern_next;
		end
	end

endmodule
`default_nettype wire

### design/stereo_led_level_meter_peak_decay.sv
// Stereo LED level meter with peak hold and decay.
// Input channel (in_valid/in_ready) takes one left and one right 10-bit
// level per transfer; output channel (out_valid/out_ready) gives one
// 8-bit LED pattern per side for every input transfer, in order.
// An item passes through two registers: the ladder index register and the
// result register. One item is taken every cycle unless the receiver
// stalls; in bar and dot modes the peak and hold counter of each side are
// read and rewritten in the same cycle the item moves into the result
// register, so nothing else limits the rate below one item per cycle.
// When the receiver stalls, the result register holds and the index
// register fills; in_ready then drops until the result is taken.
// Configuration: cfg_we with cfg_index 0 writes the display mode (this also
// clears both peaks and patterns), index 1 writes the hold time in hundreds
// of items. Write only while no item is in flight.
// Reset clears both pipeline stages, peaks, hold counters and patterns, and
// sets bar mode with zero hold time.
`default_nettype none
module stereo_led_level_meter_peak_decay
	import slm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [LEVEL_W-1:0] left_level,
	input  wire logic [LEVEL_W-1:0] right_level,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [LED_N-1:0]        left_leds,
	output logic [LED_N-1:0]        right_leds,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data
);

	mode_t            mode_q;
	logic [LIM_W-1:0] limit_q;

	level_idx_t       left_idx;
	level_idx_t       right_idx;
	level_idx_t       left_idx_s1;
	level_idx_t       right_idx_s1;
	logic             valid_s1;

	logic [LED_N-1:0] left_next;
	logic [LED_N-1:0] right_next;
	logic [LED_N-1:0] left_leds_s2;
	logic [LED_N-1:0] right_leds_s2;
	logic             valid_s2;

	logic             advance;
	logic             mode_wr;
	chan_ctrl_t       ctrl;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		mode_wr = 1'b0;
		if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PEAK_MODE:     mode_wr = 1'b1;
				REG_HOLD_HUNDREDS: mode_wr = 1'b0;
				default:           mode_wr = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BAR;
			limit_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PEAK_MODE:     mode_q  <= mode_t'(cfg_data[1:0]);
				REG_HOLD_HUNDREDS: limit_q <= LIM_W'(cfg_data) * HOLD_UNIT;
				default:           ;
			endcase
		end
	end

	assign ctrl.update = advance && (mode_q == MODE_BAR || mode_q == MODE_DOT);
	assign ctrl.clear  = mode_wr;
	assign ctrl.dot    = (mode_q == MODE_DOT);
	assign ctrl.limit  = limit_q;

	slm_ladder u_ladder_l (.level(left_level),  .index(left_idx));
	slm_ladder u_ladder_r (.level(right_level), .index(right_idx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			left_idx_s1  <= left_idx;
			right_idx_s1 <= right_idx;
		end
	end

	slm_chan u_chan_l (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.index        (left_idx_s1),
		.pattern_next (left_next)
	);

	slm_chan u_chan_r (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.index        (right_idx_s1),
		.pattern_next (right_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// fixed patterns in all-on and all-off modes, state left alone
	always_ff @(posedge clk) begin
		if (advance) begin
			case (mode_q)
				MODE_ALL_ON: begin
					left_leds_s2  <= '1;
					right_leds_s2 <= '1;
				end
				MODE_ALL_OFF: begin
					left_leds_s2  <= '0;
					right_leds_s2 <= '0;
				end
				default: begin
					left_leds_s2  <= left_next;
					right_leds_s2 <= right_next;
				end
			endcase
		end
	end

	assign out_valid  = valid_s2;
	assign left_leds  = left_leds_s2;
	assign right_leds = right_leds_s2;

endmodule
`default_nettype wire
